// ===== rtl/core/dbs_pkg.sv =====
// shared constants and types for the descending batch sorter
`default_nettype none

package dbs_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0]        count_t;

    // per-cycle command broadcast along the cell row
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dbs_cell.sv =====
// one insertion cell: holds a value and its valid bit
`default_nettype none

module dbs_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dbs_pkg::cell_ctrl_t ctrl,
    input  wire dbs_pkg::value_t     new_value,
    input  wire dbs_pkg::value_t     prev_value,
    input  wire logic                prev_valid,
    input  wire logic                prev_keep,
    input  wire dbs_pkg::value_t     next_value,
    input  wire logic                next_valid,
    output dbs_pkg::value_t          value,
    output logic                     valid,
    output logic                     keep
);
    import dbs_pkg::*;

    value_t value_reg, value_next;
    logic   valid_reg, valid_next;

    // a valid cell stays put when its value is not smaller than the incoming one
    assign keep = valid_reg && (value_reg >= new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert && !keep)
        begin
            if (prev_keep)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dbs_chain.sv =====
// row of insertion cells, sorted descending from cell 0
`default_nettype none

module dbs_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dbs_pkg::cell_ctrl_t ctrl,
    input  wire dbs_pkg::value_t     new_value,
    output dbs_pkg::value_t          head_value
);
    import dbs_pkg::*;

    value_t cell_value [CAPACITY];
    logic   cell_valid [CAPACITY];
    logic   cell_keep  [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            value_t prev_value, next_value;
            logic   prev_valid, prev_keep, next_valid;

            if (i == 0)
            begin : g_first
                assign prev_value = '0;
                assign prev_valid = 1'b0;
                assign prev_keep  = 1'b1;
            end
            else
            begin : g_mid
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_keep  = cell_keep[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            dbs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (new_value),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_keep  (prev_keep),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .keep       (cell_keep[i])
            );
        end
    endgenerate

    assign head_value = cell_value[0];

endmodule

`default_nettype wire

// ===== rtl/core/descending_batch_sorter.sv =====
// top level of the descending batch sorter: control, counters and output word
//
//  channel | handshake                   | fields
//  --------+-----------------------------+------------------------------------
//  input   | start high, busy low        | value[31:0] signed, is_last
//  result  | valid for one cycle         | sorted_value[31:0] signed, is_final,
//          |                             | overflowed
//
// fill: one input word per cycle, each inserted into the cell row in that cycle unless the row is full
// drain: after the word marked is_last, with n words stored (n at most CAPACITY,
//   n not zero), busy stays high until all n have left; one result word leaves
//   per cycle, largest first, as the cell row shifts towards its head
// result words come from an output register, in the cycle after the shift
// reset clears the state, the count, the overflow flag and the cell valid bits
// the receiver cannot stall; results are never held back
`default_nettype none

module descending_batch_sorter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dbs_pkg::value_t  value,
    input  wire logic             is_last,
    output logic                  valid,
    output dbs_pkg::value_t       sorted_value,
    output logic                  is_final,
    output logic                  overflowed
);
    import dbs_pkg::*;

    state_t     state_reg, state_next;
    count_t     count_reg, count_next;
    logic       ovf_reg, ovf_next;
    logic       valid_reg, valid_next;
    logic       final_reg, final_next;
    logic       ovf_out_reg, ovf_out_next;
    value_t     sorted_reg;
    cell_ctrl_t ctrl;
    value_t     head_value;
    logic       accept;
    logic       has_room;
    count_t     fill_count;
    logic       fill_ovf;

    assign accept   = start && (state_reg == ST_FILL);
    assign has_room = (count_reg < CAP_CNT);

    // count and overflow once the current word is taken in
    assign fill_count = (accept && has_room) ? count_reg + ONE_CNT : count_reg;
    assign fill_ovf   = ovf_reg || (accept && !has_room);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept && is_last && (fill_count != '0))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (count_reg == ONE_CNT)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        ctrl         = '0;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        valid_next   = 1'b0;
        final_next   = 1'b0;
        ovf_out_next = ovf_reg;
        case (state_reg)
            ST_FILL:
            begin
                ctrl.insert = accept && has_room;
                count_next  = fill_count;
                ovf_next    = fill_ovf;
                // empty batch end: nothing to emit, start afresh
                if (accept && is_last && (fill_count == '0))
                begin
                    ovf_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                ctrl.shift   = 1'b1;
                valid_next   = 1'b1;
                final_next   = (count_reg == ONE_CNT);
                ovf_out_next = ovf_reg;
                count_next   = count_reg - ONE_CNT;
                if (count_reg == ONE_CNT)
                begin
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    dbs_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_value  (value),
        .head_value (head_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            final_reg   <= 1'b0;
            ovf_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            valid_reg   <= valid_next;
            final_reg   <= final_next;
            ovf_out_reg <= ovf_out_next;
        end
    end

    // result word payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            sorted_reg <= head_value;
        end
    end

    assign busy         = (state_reg == ST_DRAIN);
    assign valid        = valid_reg;
    assign sorted_value = sorted_reg;
    assign is_final     = final_reg;
    assign overflowed   = ovf_out_reg;

endmodule

`default_nettype wire

// ===== tb/tb_descending_batch_sorter.sv =====
// self-checking testbench for the descending batch sorter: directed and random batches
`timescale 1ns / 1ps
`default_nettype none

module tb_descending_batch_sorter;

    import dbs_pkg::*;

    // one expected result word
    typedef struct packed {
        value_t v;
        logic   fin;
        logic   ovf;
    } sorted_word_t;

    localparam int  CLK_HALF  = 4;
    localparam int  LIMIT_NS  = 400_000;
    localparam int  QUIET_CYC = CAPACITY + 8;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    value_t value;
    logic   is_last;
    logic   valid;
    value_t sorted_value;
    logic   is_final;
    logic   overflowed;

    // shadow of the insertion row, kept in descending order
    value_t ladder [CAPACITY];
    int     ladder_count;
    logic   ladder_dropped;

    // words still owed by the block, oldest first
    sorted_word_t sorted_due[$];

    int idle_pct;
    int words_sent;
    int mismatch_count;

    descending_batch_sorter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .is_last      (is_last),
        .valid        (valid),
        .sorted_value (sorted_value),
        .is_final     (is_final),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #LIMIT_NS;
        $display("[descending_batch_sorter] ERROR");
        $finish;
    end

    // take one accepted word into the shadow row; on the batch end queue the drain
    function automatic void absorb_element(input value_t v, input logic last);
        int pos;
        int k;
        sorted_word_t w;
        if (ladder_count < CAPACITY)
        begin
            pos = 0;
            while (pos < ladder_count && ladder[pos] >= v)
                pos++;
            for (k = ladder_count; k > pos; k--)
                ladder[k] = ladder[k-1];
            ladder[pos] = v;
            ladder_count++;
        end
        else
        begin
            // row full: word is lost, the whole batch gets flagged
            ladder_dropped = 1'b1;
        end
        if (last)
        begin
            for (k = 0; k < ladder_count; k++)
            begin
                w.v   = ladder[k];
                w.fin = (k + 1 == ladder_count);
                w.ovf = ladder_dropped;
                sorted_due.push_back(w);
            end
            ladder_count   = 0;
            ladder_dropped = 1'b0;
        end
    endfunction

    // drive one word; entered and left just after a falling edge
    task automatic send_word(input value_t v, input logic last);
        // random gap with start low
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        // accepted at the first rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        absorb_element(v, last);
        words_sent++;
        @(negedge clk);
    endtask

    // hold start low until every owed word has come out
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sorted_due.size() != 0);
    endtask

    // pick a value: full range, a narrow band for duplicates, or an extreme
    function automatic value_t pick_value(input int mode);
        value_t v;
        case (mode)
            0:       v = value_t'($urandom);
            1:       v = value_t'($signed($urandom_range(8)) - 4);
            default:
            begin
                case ($urandom_range(4))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sh0000_0000;
                    3:       v = -32'sd1;
                    default: v = value_t'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    // result checker: every strobed word is matched against the oldest expectation
    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && valid)
        begin
            if (sorted_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word: expected none, got value %0d final %b ovf %b",
                         $time, sorted_value, is_final, overflowed);
            end
            else
            begin
                w = sorted_due.pop_front();
                if (sorted_value !== w.v || is_final !== w.fin || overflowed !== w.ovf)
                begin
                    mismatch_count++;
                    $display({"%0t: mismatch: expected value %0d final %b ovf %b, ",
                              "got value %0d final %b ovf %b"},
                             $time, w.v, w.fin, w.ovf, sorted_value, is_final, overflowed);
                end
            end
        end
    end

    // extremes of the range in one batch, mixed order
    task automatic test_extremes();
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b1);
    endtask

    // a batch of one: the only word is both first and final
    task automatic test_single_element();
        send_word(-32'sd7, 1'b1);
    endtask

    // repeated values must come out side by side
    task automatic test_duplicates();
        send_word(32'sd5, 1'b0);
        send_word(-32'sd3, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
    endtask

    // a full row, then the last word dropped yet still closing the batch
    task automatic test_overflow_on_last();
        int k;
        for (k = 0; k < CAPACITY; k++)
            send_word(pick_value(0), 1'b0);
        // largest possible value, so keeping it by mistake shows at once
        send_word(32'sh7FFF_FFFF, 1'b1);
    endtask

    // random batches until about n words have gone in
    task automatic run_random_batches(input int n);
        int target;
        int len;
        int mode;
        int k;
        int r;
        target = words_sent + n;
        while (words_sent < target)
        begin
            r = $urandom_range(9);
            // mostly short batches, some exactly full, some overflowing
            if (r == 0)
                len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
            else if (r == 1)
                len = CAPACITY;
            else
                len = $urandom_range(8, 1);
            mode = $urandom_range(2);
            for (k = 0; k < len; k++)
                send_word(pick_value(mode), k == len - 1);
        end
    endtask

    initial
    begin
        start          = 1'b0;
        value          = '0;
        is_last        = 1'b0;
        rst_n          = 1'b0;
        ladder_count   = 0;
        ladder_dropped = 1'b0;
        idle_pct       = 6;
        words_sent     = 0;
        mismatch_count = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_single_element();
        test_duplicates();
        test_overflow_on_last();

        // sender waits for the whole backlog before the random part
        wait_drained();
        idle_pct = 6;
        run_random_batches(70);

        // back-to-back stretch with no gaps at all
        wait_drained();
        idle_pct = 0;
        run_random_batches(35);

        wait_drained();
        // let any stray words surface before the verdict
        repeat (QUIET_CYC) @(posedge clk);

        if (mismatch_count == 0 && sorted_due.size() == 0)
            $display("[descending_batch_sorter] OK");
        else
            $display("[descending_batch_sorter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/dbs_pkg.sv
rtl/core/dbs_cell.sv
rtl/core/dbs_chain.sv
rtl/core/descending_batch_sorter.sv
tb/tb_descending_batch_sorter.sv
